@@ rtl/aptt_pkg.sv @@
// Shared constants, request codes and control structs of the ASID page translation table.
package aptt_pkg;

    localparam int ADDRESS_SPACES     = 8;
    localparam int MAPPINGS_PER_SPACE = 64;
    localparam int PAGE_SHIFT         = 12;

    localparam int TABLE_SIZE = ADDRESS_SPACES * MAPPINGS_PER_SPACE;
    localparam int ADDR_W     = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int SLOT_W     = (MAPPINGS_PER_SPACE > 1) ? $clog2(MAPPINGS_PER_SPACE) : 1;
    localparam int CNT_W      = $clog2(MAPPINGS_PER_SPACE + 1);
    localparam int PN_W       = 64 - PAGE_SHIFT;

    localparam logic [2:0] REQ_MAP    = 3'd0;
    localparam logic [2:0] REQ_UNMAP  = 3'd1;
    localparam logic [2:0] REQ_LOOKUP = 3'd2;
    localparam logic [2:0] REQ_COUNT  = 3'd3;
    localparam logic [2:0] REQ_GET    = 3'd4;

    typedef struct packed {
        logic            valid;
        logic [PN_W-1:0] vpage;
        logic [PN_W-1:0] ppage;
        logic [31:0]     flags;
    } entry_t;

    typedef struct packed {
        logic capture;
        logic clear;
        logic scan;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic slot_last;
        logic skip;
        logic out_free;
    } dp_status_t;

endpackage

@@ rtl/aptt_ctrl.sv @@
// Controller FSM: table clear after reset, slot scan, commit and result handoff.
module aptt_ctrl
    import aptt_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        s_ready     = (state_reg == ST_IDLE);
        cmd.capture = (state_reg == ST_IDLE) && s_valid;
        cmd.clear   = (state_reg == ST_CLEAR);
        cmd.scan    = (state_reg == ST_SCAN) && !status.skip;
        cmd.commit  = (state_reg == ST_COMMIT) && status.out_free;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (status.clear_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) state_next = ST_SCAN;
            end
            ST_SCAN: begin
                priority if (status.skip) state_next = ST_COMMIT;
                else if (status.slot_last) state_next = ST_DRAIN;
                else state_next = ST_SCAN;
            end
            ST_DRAIN: begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (status.out_free) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // a request is never taken before the table is cleared
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear |-> !cmd.capture)
        else $error("request taken during table clear");

    // the drain state at the end of a scan always leads into the commit state
    a_drain_to_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAIN) |=> (state_reg == ST_COMMIT))
        else $error("drain not followed by commit");

    a_commit_then_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> s_ready)
        else $error("commit did not return to idle");

endmodule

@@ rtl/aptt_dp.sv @@
// Datapath: request registers, slot table memory, scan accumulators and result register.
module aptt_dp
    import aptt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  dp_cmd_t     cmd,
    output dp_status_t  status,
    input  logic [2:0]  s_req_type,
    input  logic [7:0]  s_asid,
    input  logic [63:0] s_virt_addr,
    input  logic [63:0] s_phys_addr,
    input  logic [31:0] s_flags_in,
    input  logic [15:0] s_ordinal,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_ok,
    output logic [63:0] m_phys_addr_out,
    output logic [63:0] m_virt_addr_out,
    output logic [31:0] m_flags_out,
    output logic [6:0]  m_count
);

    // request
    logic [2:0]  req_type_reg;
    logic [7:0]  asid_reg;
    logic [63:0] va_reg;
    logic [63:0] pa_reg;
    logic [31:0] flags_reg;
    logic [15:0] ordinal_reg;

    // table
    entry_t mem [TABLE_SIZE];
    entry_t mem_q_reg;

    // scan
    logic [ADDR_W-1:0] clr_idx_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic              rd_valid_reg;
    logic [SLOT_W-1:0] rd_slot_reg;
    logic              match_found_reg;
    logic [SLOT_W-1:0] match_slot_reg;
    logic              free_found_reg;
    logic [SLOT_W-1:0] free_slot_reg;
    logic              hit_found_reg;
    entry_t            hit_entry_reg;
    logic [CNT_W-1:0]  seen_reg;

    // result
    logic        m_valid_reg;
    logic        m_ok_reg;
    logic [63:0] m_phys_reg;
    logic [63:0] m_virt_reg;
    logic [31:0] m_flags_reg;
    logic [6:0]  m_count_reg;

    logic              space_ok;
    logic              va_aligned;
    logic              pa_aligned;
    logic              skip;
    logic [PN_W-1:0]   req_vpage;
    logic [ADDR_W-1:0] base_addr;
    logic [ADDR_W-1:0] scan_addr;
    logic              rd_match;
    logic              rd_hit;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    entry_t            wr_data;
    logic [CNT_W+6:0]  seen_ext;
    logic              res_ok;
    logic [63:0]       res_phys;
    logic [63:0]       res_virt;
    logic [31:0]       res_flags;
    logic [6:0]        res_count;

    assign space_ok   = {1'b0, asid_reg} < 9'(ADDRESS_SPACES);
    assign va_aligned = (va_reg[PAGE_SHIFT-1:0] == '0);
    assign pa_aligned = (pa_reg[PAGE_SHIFT-1:0] == '0);
    assign req_vpage  = va_reg[63:PAGE_SHIFT];
    assign base_addr  = ADDR_W'(ADDR_W'(asid_reg) * ADDR_W'(MAPPINGS_PER_SPACE));
    assign scan_addr  = base_addr + ADDR_W'(slot_reg);
    assign seen_ext   = {7'd0, seen_reg};

    always_comb begin
        case (req_type_reg)
            REQ_MAP:    skip = !space_ok || (flags_reg == '0) || !va_aligned || !pa_aligned;
            REQ_UNMAP:  skip = !space_ok || !va_aligned;
            REQ_LOOKUP: skip = !space_ok;
            REQ_COUNT:  skip = !space_ok;
            REQ_GET:    skip = !space_ok;
            default:    skip = 1'b1;
        endcase
    end

    assign status.clear_last = (clr_idx_reg == ADDR_W'(TABLE_SIZE - 1));
    assign status.slot_last  = (slot_reg == SLOT_W'(MAPPINGS_PER_SPACE - 1));
    assign status.skip       = skip;
    assign status.out_free   = !m_valid_reg || m_ready;

    // lookup keys on the first matching valid slot, get on the ordinal-th valid one
    assign rd_match = mem_q_reg.valid && (mem_q_reg.vpage == req_vpage);
    assign rd_hit   = (req_type_reg == REQ_GET)
                    ? (mem_q_reg.valid && (16'(seen_reg) == ordinal_reg))
                    : rd_match;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = clr_idx_reg;
        wr_data = '0;
        if (cmd.clear) begin
            wr_en = 1'b1;
        end else if (cmd.commit && !skip) begin
            if (req_type_reg == REQ_MAP) begin
                wr_data.valid = 1'b1;
                wr_data.vpage = req_vpage;
                wr_data.ppage = pa_reg[63:PAGE_SHIFT];
                wr_data.flags = flags_reg;
                if (match_found_reg) begin
                    wr_en   = 1'b1;
                    wr_addr = base_addr + ADDR_W'(match_slot_reg);
                end else if (free_found_reg) begin
                    wr_en   = 1'b1;
                    wr_addr = base_addr + ADDR_W'(free_slot_reg);
                end
            end else if (req_type_reg == REQ_UNMAP) begin
                wr_en   = match_found_reg;
                wr_addr = base_addr + ADDR_W'(match_slot_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.scan) begin
            mem_q_reg <= mem[scan_addr];
        end
    end

    always_comb begin
        res_ok    = 1'b0;
        res_phys  = '0;
        res_virt  = '0;
        res_flags = '0;
        res_count = '0;
        if (!skip) begin
            case (req_type_reg)
                REQ_MAP: begin
                    res_ok = match_found_reg || free_found_reg;
                end
                REQ_UNMAP: begin
                    res_ok = match_found_reg;
                end
                REQ_LOOKUP: begin
                    if (hit_found_reg) begin
                        res_ok    = 1'b1;
                        res_phys  = {hit_entry_reg.ppage, va_reg[PAGE_SHIFT-1:0]};
                        res_flags = hit_entry_reg.flags;
                    end
                end
                REQ_COUNT: begin
                    res_ok    = 1'b1;
                    res_count = seen_ext[6:0];
                end
                REQ_GET: begin
                    if (hit_found_reg) begin
                        res_ok    = 1'b1;
                        res_phys  = {hit_entry_reg.ppage, {PAGE_SHIFT{1'b0}}};
                        res_virt  = {hit_entry_reg.vpage, {PAGE_SHIFT{1'b0}}};
                        res_flags = hit_entry_reg.flags;
                    end
                end
                default: begin
                    res_ok = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_type_reg <= s_req_type;
            asid_reg     <= s_asid;
            va_reg       <= s_virt_addr;
            pa_reg       <= s_phys_addr;
            flags_reg    <= s_flags_in;
            ordinal_reg  <= s_ordinal;
        end
        if (rd_valid_reg && rd_hit && !hit_found_reg) begin
            hit_entry_reg <= mem_q_reg;
        end
        if (cmd.commit) begin
            m_ok_reg    <= res_ok;
            m_phys_reg  <= res_phys;
            m_virt_reg  <= res_virt;
            m_flags_reg <= res_flags;
            m_count_reg <= res_count;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_idx_reg     <= '0;
            slot_reg        <= '0;
            rd_valid_reg    <= 1'b0;
            rd_slot_reg     <= '0;
            match_found_reg <= 1'b0;
            match_slot_reg  <= '0;
            free_found_reg  <= 1'b0;
            free_slot_reg   <= '0;
            hit_found_reg   <= 1'b0;
            seen_reg        <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cmd.clear) begin
                clr_idx_reg <= clr_idx_reg + ADDR_W'(1);
            end
            rd_valid_reg <= cmd.scan;
            rd_slot_reg  <= slot_reg;
            if (cmd.capture) begin
                slot_reg        <= '0;
                match_found_reg <= 1'b0;
                free_found_reg  <= 1'b0;
                hit_found_reg   <= 1'b0;
                seen_reg        <= '0;
            end else begin
                if (cmd.scan) begin
                    slot_reg <= slot_reg + SLOT_W'(1);
                end
                if (rd_valid_reg) begin
                    if (rd_match && !match_found_reg) begin
                        match_found_reg <= 1'b1;
                        match_slot_reg  <= rd_slot_reg;
                    end
                    if (!mem_q_reg.valid && !free_found_reg) begin
                        free_found_reg <= 1'b1;
                        free_slot_reg  <= rd_slot_reg;
                    end
                    if (rd_hit) begin
                        hit_found_reg <= 1'b1;
                    end
                    if (mem_q_reg.valid) begin
                        seen_reg <= seen_reg + CNT_W'(1);
                    end
                end
            end
            if (cmd.commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_ok            = m_ok_reg;
    assign m_phys_addr_out = m_phys_reg;
    assign m_virt_addr_out = m_virt_reg;
    assign m_flags_out     = m_flags_reg;
    assign m_count         = m_count_reg;

    // the result register is only reloaded once the previous result has gone out
    a_commit_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!m_valid_reg || m_ready))
        else $error("result overwritten before transfer");

    // read data is only consumed in the cycle after a scan read
    a_rd_after_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_valid_reg |-> $past(cmd.scan))
        else $error("read data flagged without a scan read");

    // a slot cannot be both the match and the free slot
    a_match_free_differ: assert property (@(posedge aclk) disable iff (!aresetn)
        (match_found_reg && free_found_reg) |-> (match_slot_reg != free_slot_reg))
        else $error("match and free slot coincide");

    // failures and misses carry an all-zero payload
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ok_reg) |->
            (m_phys_reg == '0 && m_virt_reg == '0 && m_flags_reg == '0 && m_count_reg == '0))
        else $error("nonzero payload on failed request");

endmodule

@@ rtl/asid_page_translation_table.sv @@
// Top level of the per-address-space page translation table.
//
//  channel | direction | handshake           | payload
//  s_*     | in        | s_valid / s_ready   | req_type, asid, virt_addr, phys_addr, flags_in, ordinal
//  m_*     | out       | m_valid / m_ready   | ok, phys_addr_out, virt_addr_out, flags_out, count
//
// From transfer to the next s_ready a request goes through one read of the slot table per
// slot of the space, a drain state for the last read data, and one commit.
// Requests rejected on their fields (space, alignment, zero flags, unknown type) skip the scan and go to the commit.
// After reset the table is cleared one entry a cycle, all TABLE_SIZE (512) entries, with s_ready low.
// A result waits in the output register; the next request is taken meanwhile and holds
// in its commit cycle only while that earlier result is still not transferred.
module asid_page_translation_table
    import aptt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_req_type,
    input  logic [7:0]  s_asid,
    input  logic [63:0] s_virt_addr,
    input  logic [63:0] s_phys_addr,
    input  logic [31:0] s_flags_in,
    input  logic [15:0] s_ordinal,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_ok,
    output logic [63:0] m_phys_addr_out,
    output logic [63:0] m_virt_addr_out,
    output logic [31:0] m_flags_out,
    output logic [6:0]  m_count
);

    dp_cmd_t    cmd;
    dp_status_t status;

    aptt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    aptt_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .s_req_type      (s_req_type),
        .s_asid          (s_asid),
        .s_virt_addr     (s_virt_addr),
        .s_phys_addr     (s_phys_addr),
        .s_flags_in      (s_flags_in),
        .s_ordinal       (s_ordinal),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_ok            (m_ok),
        .m_phys_addr_out (m_phys_addr_out),
        .m_virt_addr_out (m_virt_addr_out),
        .m_flags_out     (m_flags_out),
        .m_count         (m_count)
    );

endmodule
